// ===== design/rplb_pkg.sv =====
package rplb_pkg;

	localparam int DEF_MEMORY_DEPTH = 4096;
	localparam int DEF_SAMPLE_BITS  = 24;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 25;
	localparam int LEN_W       = 13;
	localparam int REC_INC_W   = 24;
	localparam int PLAY_INC_W  = 24;
	localparam int INV_W       = 25;
	localparam int PHASE_W     = 32;
	localparam int FRAC_BITS   = 16;
	localparam int IDX_W       = PHASE_W - FRAC_BITS;
	localparam int LW_W        = LEN_W + 1;
	localparam int SYNC_W      = 18;
	localparam int MODE_W      = 3;
	localparam int CMD_W       = 3;
	localparam int PROD_W      = PHASE_W + INV_W + 1;
	localparam int SYNC_SHIFT  = 24;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic [LEN_W-1:0]      RST_BUFFER_LENGTH    = 13'd1280;
	localparam logic [REC_INC_W-1:0]  RST_RECORD_INCREMENT = 24'd190;
	localparam logic [PLAY_INC_W-1:0] RST_PLAY_INCREMENT   = 24'd190;
	localparam logic [INV_W-1:0]      RST_INVERSE_LENGTH   = 25'd13107;

	localparam logic [PHASE_W-1:0] ONE_ENTRY = 32'h0001_0000;

	localparam logic [SYNC_W-1:0] SYNC_MAX = 18'h1FFFF;
	localparam logic [SYNC_W-1:0] SYNC_MIN = 18'h20000;

	localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_LENGTH    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RECORD_INCREMENT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PLAY_INCREMENT   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_LENGTH   = 2'd3;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RECORD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOOP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_STOP   = 3'd5;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE   = 3'd0,
		MODE_RECORD = 3'd1,
		MODE_PLAY   = 3'd2,
		MODE_LOOP   = 3'd3,
		MODE_DUMP   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_SAMPLE,
		SEL_STORE
	} out_sel_t;

	typedef struct packed {
		logic     valid;
		out_sel_t sel;
		logic     sync_en;
		mode_t    mode;
	} tick_ctl_t;

endpackage

// ===== design/rplb_store.sv =====
module rplb_store #(
	parameter int MEMORY_DEPTH = rplb_pkg::DEF_MEMORY_DEPTH,
	parameter int SAMPLE_BITS  = rplb_pkg::DEF_SAMPLE_BITS,
	parameter int ADDR_W       = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic                   re,
	input  logic [ADDR_W-1:0]      addr,
	input  logic [SAMPLE_BITS-1:0] wdata,
	output logic [SAMPLE_BITS-1:0] rdata_s1
);

	logic [SAMPLE_BITS-1:0] mem [MEMORY_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[addr];
		end
	end

endmodule

// ===== design/rplb_ctrl.sv =====
module rplb_ctrl #(
	parameter int MEMORY_DEPTH = rplb_pkg::DEF_MEMORY_DEPTH,
	parameter int SAMPLE_BITS  = rplb_pkg::DEF_SAMPLE_BITS,
	parameter int ADDR_W       = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rplb_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [rplb_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  item_accept,
	input  logic [rplb_pkg::CMD_W-1:0]            command,
	input  logic [SAMPLE_BITS-1:0]                sample_value,
	output logic                                  clearing,
	output logic                                  mem_we,
	output logic                                  mem_re,
	output logic [ADDR_W-1:0]                     mem_addr,
	output logic [SAMPLE_BITS-1:0]                mem_wdata,
	output rplb_pkg::tick_ctl_t                   ctl_s1,
	output logic [SAMPLE_BITS-1:0]                sample_s1,
	output logic [rplb_pkg::PHASE_W-1:0]          phase_s1,
	output logic [rplb_pkg::INV_W-1:0]            inverse_length
);

	import rplb_pkg::*;

	logic [LEN_W-1:0]      buffer_length_q;
	logic [REC_INC_W-1:0]  record_increment_q;
	logic [PLAY_INC_W-1:0] play_increment_q;
	logic [INV_W-1:0]      inverse_length_q;

	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	mode_t                   mode_q, mode_n;
	logic [PHASE_W-1:0]      phase_q, phase_n;
	logic signed [LW_W-1:0]  lw_q, lw_n;

	logic [LEN_W-1:0]        len_used;
	logic [LEN_W-1:0]        len_m1;
	logic [IDX_W-1:0]        idx;
	logic signed [IDX_W-1:0] lw_ext;
	logic                    idx_ge_len;
	logic                    idx_neg;
	logic                    idx_gt_lw;
	logic                    is_tick;
	logic [PHASE_W-1:0]      rec_sum;
	logic [PHASE_W-1:0]      play_sum;
	logic [PHASE_W-1:0]      dump_sum;
	logic [PHASE_W-1:0]      wrap_phase;

	logic [LEN_W-1:0] acc_idx;
	logic             acc_wr;
	logic             acc_rd;
	tick_ctl_t        ctl_n;

	always_comb begin
		if (buffer_length_q == '0) begin
			len_used = LEN_W'(1);
		end else if (32'(buffer_length_q) > 32'(MEMORY_DEPTH)) begin
			len_used = LEN_W'(MEMORY_DEPTH);
		end else begin
			len_used = buffer_length_q;
		end
	end

	assign len_m1     = len_used - LEN_W'(1);
	assign idx        = phase_q[PHASE_W-1:FRAC_BITS];
	assign lw_ext     = IDX_W'(lw_q);
	assign idx_ge_len = $signed(idx) >= $signed(IDX_W'(len_used));
	assign idx_neg    = idx[IDX_W-1];
	assign idx_gt_lw  = $signed(idx) > lw_ext;
	assign is_tick    = item_accept && (command == CMD_TICK);
	assign rec_sum    = phase_q + PHASE_W'(record_increment_q);
	assign play_sum   = phase_q + {{(PHASE_W-PLAY_INC_W){play_increment_q[PLAY_INC_W-1]}},
		play_increment_q};
	assign dump_sum   = phase_q + ONE_ENTRY;
	assign wrap_phase = PHASE_W'({len_m1, {FRAC_BITS{1'b0}}});

	// Next state of mode, phase and last written index.
	always_comb begin
		mode_n  = mode_q;
		phase_n = phase_q;
		lw_n    = lw_q;
		if (item_accept && command != CMD_TICK) begin
			unique case (command)
				CMD_RECORD: mode_n = MODE_RECORD;
				CMD_PLAY:   mode_n = MODE_PLAY;
				CMD_LOOP:   mode_n = MODE_LOOP;
				CMD_DUMP:   mode_n = MODE_DUMP;
				CMD_STOP:   mode_n = MODE_IDLE;
				default:    mode_n = mode_q;
			endcase
			if (command <= CMD_STOP) begin
				phase_n = '0;
				lw_n    = '1;
			end
		end else if (is_tick) begin
			unique case (mode_q)
				MODE_RECORD: begin
					phase_n = rec_sum;
					if (idx_ge_len) begin
						mode_n = MODE_IDLE;
					end else if (idx_gt_lw) begin
						lw_n = LW_W'(idx[LEN_W-1:0]);
					end
				end
				MODE_PLAY: begin
					phase_n = play_sum;
					if (idx_ge_len || idx_neg) begin
						mode_n = MODE_IDLE;
					end
				end
				MODE_LOOP: begin
					if (idx_ge_len) begin
						phase_n = '0;
					end else if (idx_neg) begin
						phase_n = wrap_phase;
					end else begin
						phase_n = play_sum;
					end
				end
				MODE_DUMP: begin
					phase_n = dump_sum;
					if (idx_ge_len || idx_neg) begin
						mode_n = MODE_IDLE;
					end
				end
				default: begin
					mode_n = mode_q;
				end
			endcase
		end
	end

	// Store access and result control for the tick.
	always_comb begin
		acc_idx       = idx[LEN_W-1:0];
		acc_wr        = 1'b0;
		acc_rd        = 1'b0;
		ctl_n.valid   = is_tick;
		ctl_n.sel     = SEL_ZERO;
		ctl_n.sync_en = 1'b0;
		ctl_n.mode    = mode_n;
		unique case (mode_q)
			MODE_RECORD: begin
				acc_wr        = is_tick && !idx_ge_len && idx_gt_lw;
				ctl_n.sel     = SEL_SAMPLE;
				ctl_n.sync_en = 1'b1;
			end
			MODE_PLAY: begin
				acc_rd        = is_tick;
				ctl_n.sel     = SEL_STORE;
				ctl_n.sync_en = 1'b1;
				if (idx_ge_len) begin
					acc_idx = len_m1;
				end else if (idx_neg) begin
					acc_idx = '0;
				end
			end
			MODE_LOOP: begin
				acc_rd        = is_tick;
				ctl_n.sel     = SEL_STORE;
				ctl_n.sync_en = 1'b1;
				if (idx_ge_len) begin
					acc_idx = '0;
				end else if (idx_neg) begin
					acc_idx = len_m1;
				end
			end
			MODE_DUMP: begin
				if (!(idx_ge_len || idx_neg)) begin
					acc_rd    = is_tick;
					ctl_n.sel = SEL_STORE;
				end
			end
			default: begin
				ctl_n.sel = SEL_ZERO;
			end
		endcase
	end

	// The clearing pass owns the write port; no item is taken meanwhile.
	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_re    = 1'b0;
			mem_addr  = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = acc_wr;
			mem_re    = acc_rd;
			mem_addr  = ADDR_W'(acc_idx);
			mem_wdata = sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q    <= RST_BUFFER_LENGTH;
			record_increment_q <= RST_RECORD_INCREMENT;
			play_increment_q   <= RST_PLAY_INCREMENT;
			inverse_length_q   <= RST_INVERSE_LENGTH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUFFER_LENGTH:    buffer_length_q    <= cfg_data[LEN_W-1:0];
				REG_RECORD_INCREMENT: record_increment_q <= cfg_data[REC_INC_W-1:0];
				REG_PLAY_INCREMENT:   play_increment_q   <= cfg_data[PLAY_INC_W-1:0];
				REG_INVERSE_LENGTH:   inverse_length_q   <= cfg_data[INV_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (cfg_we && cfg_index == REG_BUFFER_LENGTH) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(MEMORY_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			phase_q <= '0;
			lw_q    <= '1;
			ctl_s1  <= '0;
		end else begin
			mode_q  <= mode_n;
			phase_q <= phase_n;
			lw_q    <= lw_n;
			ctl_s1  <= ctl_n;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= sample_value;
		phase_s1  <= phase_n;
	end

	assign clearing       = clearing_q;
	assign inverse_length = inverse_length_q;

endmodule

// ===== design/rplb_post.sv =====
module rplb_post #(
	parameter int SAMPLE_BITS = rplb_pkg::DEF_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rplb_pkg::tick_ctl_t              ctl_s1,
	input  logic [SAMPLE_BITS-1:0]           sample_s1,
	input  logic [SAMPLE_BITS-1:0]           rdata_s1,
	input  logic [rplb_pkg::PHASE_W-1:0]     phase_s1,
	input  logic [rplb_pkg::INV_W-1:0]       inverse_length,
	output logic                             res_push,
	output logic [SAMPLE_BITS-1:0]           res_sample,
	output logic [rplb_pkg::SYNC_W-1:0]      res_sync,
	output rplb_pkg::mode_t                  res_mode
);

	import rplb_pkg::*;

	localparam int SH_W = PROD_W - SYNC_SHIFT;

	tick_ctl_t                ctl_s2;
	logic [SAMPLE_BITS-1:0]   sample_s2;
	logic signed [PROD_W-1:0] product;
	logic signed [PROD_W-1:0] product_s2;
	logic [SAMPLE_BITS-1:0]   sample_sel;
	logic signed [SH_W-1:0]   shifted;
	logic [SYNC_W-1:0]        sync_sat;

	assign product = PROD_W'($signed(phase_s1)) * PROD_W'($signed({1'b0, inverse_length}));

	always_comb begin
		unique case (ctl_s1.sel)
			SEL_SAMPLE: sample_sel = sample_s1;
			SEL_STORE:  sample_sel = rdata_s1;
			default:    sample_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		sample_s2  <= sample_sel;
		product_s2 <= product;
	end

	// Dropping the low bits of a two's complement product rounds toward minus infinity.
	assign shifted = product_s2[PROD_W-1:SYNC_SHIFT];

	always_comb begin
		if (shifted > $signed(SH_W'(SYNC_MAX))) begin
			sync_sat = SYNC_MAX;
		end else if (shifted < $signed({{(SH_W-SYNC_W){1'b1}}, SYNC_MIN})) begin
			sync_sat = SYNC_MIN;
		end else begin
			sync_sat = shifted[SYNC_W-1:0];
		end
	end

	assign res_push   = ctl_s2.valid;
	assign res_sample = sample_s2;
	assign res_sync   = ctl_s2.sync_en ? sync_sat : '0;
	assign res_mode   = ctl_s2.mode;

endmodule

// ===== design/rplb_fifo.sv =====
module rplb_fifo #(
	parameter int SAMPLE_BITS = rplb_pkg::DEF_SAMPLE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        claim,
	output logic                        full,
	input  logic                        push,
	input  logic [SAMPLE_BITS-1:0]      push_sample,
	input  logic [rplb_pkg::SYNC_W-1:0] push_sync,
	input  rplb_pkg::mode_t             push_mode,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [SAMPLE_BITS-1:0]      output_sample,
	output logic [rplb_pkg::SYNC_W-1:0] sync_value,
	output logic [rplb_pkg::MODE_W-1:0] active_mode
);

	import rplb_pkg::*;

	logic [SAMPLE_BITS-1:0] sample_q [FIFO_DEPTH];
	logic [SYNC_W-1:0]      sync_q   [FIFO_DEPTH];
	mode_t                  mode_q   [FIFO_DEPTH];

	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] occ_q;
	logic [FIFO_CNT_W-1:0] credit_q;
	logic                  pop;

	assign result_valid  = occ_q != '0;
	assign pop           = result_valid && !result_stall;
	assign full          = credit_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign output_sample = sample_q[rd_ptr_q];
	assign sync_value    = sync_q[rd_ptr_q];
	assign active_mode   = mode_q[rd_ptr_q];

	// Credits count every tick from its acceptance until its result leaves, so the queue never overflows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			occ_q    <= occ_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
			credit_q <= credit_q + FIFO_CNT_W'(claim) - FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			sample_q[wr_ptr_q] <= push_sample;
			sync_q[wr_ptr_q]   <= push_sync;
			mode_q[wr_ptr_q]   <= push_mode;
		end
	end

endmodule

// ===== design/record_play_loop_buffer_top.sv =====
// Channel  Direction  Handshake            Beat contents
// item     in         item_valid/stall     command, sample_value
// result   out        result_valid/stall   output_sample, sync_value, active_mode
// config   in         cfg_we               cfg_index, cfg_data
//
// One beat is taken per clock while item_stall is low; a sample tick's result passes through
// the store read, the sync multiply register and the result queue write.
// After reset and after every buffer_length write the store is zeroed, one entry a
// cycle, and item_stall stays high until every entry has been cleared.
// A four-entry result queue with credit counting lets beats keep coming while results wait.
module record_play_loop_buffer_top #(
	parameter int MEMORY_DEPTH = rplb_pkg::DEF_MEMORY_DEPTH,
	parameter int SAMPLE_BITS  = rplb_pkg::DEF_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rplb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rplb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [rplb_pkg::CMD_W-1:0]       command,
	input  logic signed [SAMPLE_BITS-1:0]    sample_value,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [SAMPLE_BITS-1:0]    output_sample,
	output logic signed [rplb_pkg::SYNC_W-1:0] sync_value,
	output logic [rplb_pkg::MODE_W-1:0]      active_mode
);

	import rplb_pkg::*;

	localparam int ADDR_W = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;

	logic                   item_accept;
	logic                   clearing;
	logic                   full;
	logic                   mem_we;
	logic                   mem_re;
	logic [ADDR_W-1:0]      mem_addr;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic [SAMPLE_BITS-1:0] rdata_s1;
	tick_ctl_t              ctl_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [PHASE_W-1:0]     phase_s1;
	logic [INV_W-1:0]       inverse_length;
	logic                   res_push;
	logic [SAMPLE_BITS-1:0] res_sample;
	logic [SYNC_W-1:0]      res_sync;
	mode_t                  res_mode;

	assign item_stall  = clearing || full;
	assign item_accept = item_valid && !item_stall;

	rplb_ctrl #(
		.MEMORY_DEPTH (MEMORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.ADDR_W       (ADDR_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_accept    (item_accept),
		.command        (command),
		.sample_value   (sample_value),
		.clearing       (clearing),
		.mem_we         (mem_we),
		.mem_re         (mem_re),
		.mem_addr       (mem_addr),
		.mem_wdata      (mem_wdata),
		.ctl_s1         (ctl_s1),
		.sample_s1      (sample_s1),
		.phase_s1       (phase_s1),
		.inverse_length (inverse_length)
	);

	rplb_store #(
		.MEMORY_DEPTH (MEMORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.ADDR_W       (ADDR_W)
	) u_store (
		.clk      (clk),
		.we       (mem_we),
		.re       (mem_re),
		.addr     (mem_addr),
		.wdata    (mem_wdata),
		.rdata_s1 (rdata_s1)
	);

	rplb_post #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl_s1         (ctl_s1),
		.sample_s1      (sample_s1),
		.rdata_s1       (rdata_s1),
		.phase_s1       (phase_s1),
		.inverse_length (inverse_length),
		.res_push       (res_push),
		.res_sample     (res_sample),
		.res_sync       (res_sync),
		.res_mode       (res_mode)
	);

	rplb_fifo #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.claim         (item_accept && command == CMD_TICK),
		.full          (full),
		.push          (res_push),
		.push_sample   (res_sample),
		.push_sync     (res_sync),
		.push_mode     (res_mode),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.output_sample (output_sample),
		.sync_value    (sync_value),
		.active_mode   (active_mode)
	);

endmodule

// ===== tb/tb_record_play_loop_buffer_top.sv =====
`timescale 1ns / 1ps

module tb_record_play_loop_buffer_top;
	import rplb_pkg::*;

	localparam int DEPTH        = DEF_MEMORY_DEPTH;
	localparam int SBITS        = DEF_SAMPLE_BITS;
	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int SEGMENTS     = 8;
	localparam int SEG_ITEMS    = 64;
	localparam int PRINT_CAP    = 50;
	localparam longint SYNC_HI  = 131071;
	localparam longint SYNC_LO  = -131072;

	// Command codes that the block must ignore.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [SBITS-1:0] smp;
	} beat_t;

	typedef struct {
		logic [SBITS-1:0]  smp;
		logic [SYNC_W-1:0] sync;
		mode_t             mode;
	} tick_out_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	logic [CMD_W-1:0]        command = '0;
	logic signed [SBITS-1:0] sample_value = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic signed [SBITS-1:0] output_sample;
	logic signed [SYNC_W-1:0] sync_value;
	logic [MODE_W-1:0]       active_mode;

	// Shadow copy of the looper state and its registers.
	logic [SBITS-1:0]             shadow_store [DEPTH];
	longint                       phase;
	int                           last_idx;
	mode_t                        looper_mode;
	logic [LEN_W-1:0]             len_reg;
	logic [REC_INC_W-1:0]         rec_step;
	logic signed [PLAY_INC_W-1:0] play_step;
	logic [INV_W-1:0]             inv_len;

	beat_t     beats_to_send[$];
	tick_out_t tick_outputs_due[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int holds_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int ticks_seen = 0;

	record_play_loop_buffer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.sample_value (sample_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.output_sample(output_sample),
		.sync_value   (sync_value),
		.active_mode  (active_mode)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [SYNC_W-1:0] sync_from_phase(longint ph);
		longint s;
		s = (ph * longint'(inv_len)) >>> SYNC_SHIFT;
		if (s > SYNC_HI)
			s = SYNC_HI;
		else if (s < SYNC_LO)
			s = SYNC_LO;
		return s[SYNC_W-1:0];
	endfunction

	task automatic step_looper(input logic [CMD_W-1:0] cmd, input logic [SBITS-1:0] smp);
		longint len;
		longint idx;
		tick_out_t r;
		len = (len_reg == 0) ? 1 : (len_reg > DEPTH) ? DEPTH : longint'(len_reg);
		case (cmd)
			CMD_RECORD: looper_mode = MODE_RECORD;
			CMD_PLAY:   looper_mode = MODE_PLAY;
			CMD_LOOP:   looper_mode = MODE_LOOP;
			CMD_DUMP:   looper_mode = MODE_DUMP;
			CMD_STOP:   looper_mode = MODE_IDLE;
			default: ;
		endcase
		if (cmd != CMD_TICK) begin
			if (cmd <= CMD_STOP) begin
				phase = 0;
				last_idx = -1;
			end
			return;
		end
		idx = phase >>> FRAC_BITS;
		r.smp = '0;
		r.sync = '0;
		case (looper_mode)
			MODE_RECORD: begin
				phase = phase + longint'(rec_step);
				if (idx >= len) begin
					looper_mode = MODE_IDLE;
				end else if (idx > last_idx) begin
					last_idx = int'(idx);
					shadow_store[int'(idx)] = smp;
				end
				r.smp = smp;
				r.sync = sync_from_phase(phase);
			end
			MODE_PLAY: begin
				phase = phase + longint'(play_step);
				if (idx >= len) begin
					looper_mode = MODE_IDLE;
					r.smp = shadow_store[int'(len - 1)];
				end else if (idx < 0) begin
					looper_mode = MODE_IDLE;
					r.smp = shadow_store[0];
				end else begin
					r.smp = shadow_store[int'(idx)];
				end
				r.sync = sync_from_phase(phase);
			end
			MODE_LOOP: begin
				phase = phase + longint'(play_step);
				if (idx >= len) begin
					idx = 0;
					phase = 0;
				end else if (idx < 0) begin
					idx = len - 1;
					phase = idx <<< FRAC_BITS;
				end
				r.smp = shadow_store[int'(idx)];
				r.sync = sync_from_phase(phase);
			end
			MODE_DUMP: begin
				phase = phase + longint'(ONE_ENTRY);
				if (idx >= len || idx < 0)
					looper_mode = MODE_IDLE;
				else
					r.smp = shadow_store[int'(idx)];
			end
			default: ;
		endcase
		r.mode = looper_mode;
		tick_outputs_due.push_back(r);
	endtask

	task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BUFFER_LENGTH: begin
				len_reg = val[LEN_W-1:0];
				foreach (shadow_store[i])
					shadow_store[i] = '0;
			end
			REG_RECORD_INCREMENT: rec_step = val[REC_INC_W-1:0];
			REG_PLAY_INCREMENT:   play_step = val[PLAY_INC_W-1:0];
			REG_INVERSE_LENGTH:   inv_len = val[INV_W-1:0];
			default: ;
		endcase
	endtask

	// The length goes last since writing it starts the clearing pass.
	task automatic apply_setting(input logic [LEN_W-1:0] l, input logic [REC_INC_W-1:0] r,
			input logic [PLAY_INC_W-1:0] p, input logic [INV_W-1:0] v, input bit write_len);
		set_register(REG_RECORD_INCREMENT, CFG_DATA_W'(r));
		set_register(REG_PLAY_INCREMENT, CFG_DATA_W'(p));
		set_register(REG_INVERSE_LENGTH, CFG_DATA_W'(v));
		if (write_len)
			set_register(REG_BUFFER_LENGTH, CFG_DATA_W'(l));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_until_drained();
		while (beats_to_send.size() != 0 || item_valid || tick_outputs_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic push_beat(input logic [CMD_W-1:0] c, input logic [SBITS-1:0] s);
		beat_t b;
		b.cmd = c;
		b.smp = s;
		beats_to_send.push_back(b);
	endtask

	// Mostly a mode command followed by a run of ticks, with some stray beats mixed in.
	task automatic fill_segment(input int n);
		int made;
		int nt;
		int pick;
		int ul;
		int cap;
		logic [CMD_W-1:0] c;
		made = 0;
		ul = (len_reg == 0) ? 1 : (len_reg > DEPTH) ? DEPTH : int'(len_reg);
		cap = (2 * ul + 6 > 40) ? 40 : 2 * ul + 6;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				c = CMD_W'($urandom_range(0, 7));
				push_beat(c, SBITS'($urandom));
				if (c <= CMD_STOP)
					made++;
			end else begin
				pick = $urandom_range(0, 9);
				c = (pick < 3) ? CMD_RECORD : (pick < 5) ? CMD_PLAY :
					(pick < 7) ? CMD_LOOP : (pick < 9) ? CMD_DUMP : CMD_STOP;
				push_beat(c, SBITS'($urandom));
				nt = $urandom_range(1, cap);
				repeat (nt) push_beat(CMD_TICK, SBITS'($urandom));
				made += nt + 1;
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t: tick %0d %s: got %0h, want %0h", $realtime, ticks_seen, what,
				got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		beat_t b;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				step_looper(command, sample_value);
			if (!item_valid || !item_stall) begin
				if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					b = beats_to_send.pop_front();
					item_valid <= 1'b1;
					command <= b.cmd;
					sample_value <= b.smp;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// A long hold-off starts only while beats are flowing, so the block backs up.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (holds_served != hold_request && item_valid && !item_stall) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		tick_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (tick_outputs_due.size() == 0) begin
				flag_mismatch("beat with nothing due", 32'(output_sample), '0);
			end else begin
				want = tick_outputs_due.pop_front();
				if (output_sample !== want.smp)
					flag_mismatch("output_sample", 32'(output_sample), 32'(want.smp));
				if (sync_value !== want.sync)
					flag_mismatch("sync_value", 32'(sync_value), 32'(want.sync));
				if (active_mode !== want.mode)
					flag_mismatch("active_mode", 32'(active_mode), 32'(want.mode));
			end
			ticks_seen <= ticks_seen + 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("no beat moved for %0d cycles", QUIET_LIMIT);
			$display("tb_record_play_loop_buffer_top: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int seg;
		int ul;
		logic [LEN_W-1:0] l;
		logic [REC_INC_W-1:0] r;
		logic [PLAY_INC_W-1:0] p;
		logic [INV_W-1:0] v;

		foreach (shadow_store[i])
			shadow_store[i] = '0;
		phase = 0;
		last_idx = -1;
		looper_mode = MODE_IDLE;
		len_reg = RST_BUFFER_LENGTH;
		rec_step = RST_RECORD_INCREMENT;
		play_step = RST_PLAY_INCREMENT;
		inv_len = RST_INVERSE_LENGTH;
		send_idle_pct = 38;
		recv_idle_pct = 76;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait_until_drained();

		// Four entries, one entry per tick in every mode.
		apply_setting(13'd4, 24'd65536, 24'd65536, 25'd4194304, 1'b1);
		push_beat(CMD_TICK, 24'h7FFFFF);
		push_beat(CMD_SPARE_LO, 24'h000001);
		push_beat(CMD_SPARE_HI, 24'h800000);
		push_beat(CMD_RECORD, 24'h0);
		push_beat(CMD_TICK, 24'h7FFFFF);
		push_beat(CMD_TICK, 24'h800000);
		push_beat(CMD_TICK, 24'h000000);
		push_beat(CMD_TICK, 24'hFFFFFF);
		push_beat(CMD_TICK, 24'h5A5A5A);
		push_beat(CMD_PLAY, 24'h0);
		push_beat(CMD_TICK, 24'h0);
		push_beat(CMD_TICK, 24'h0);
		push_beat(CMD_LOOP, 24'h0);
		repeat (5) push_beat(CMD_TICK, 24'h0);
		push_beat(CMD_DUMP, 24'h0);
		repeat (5) push_beat(CMD_TICK, 24'h0);
		push_beat(CMD_STOP, 24'h0);
		push_beat(CMD_TICK, 24'h123456);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			wait_until_drained();
			if (seg < 3) begin
				send_idle_pct = 38;
				recv_idle_pct = 76;
			end else if (seg < 6) begin
				send_idle_pct = 76;
				recv_idle_pct = 38;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			l = LEN_W'($urandom_range(2, 40));
			r = REC_INC_W'($urandom_range(4096, 180000));
			p = PLAY_INC_W'($urandom_range(0, 360000) - 180000);
			case (seg)
				0: begin
					l = 13'd1;
					r = 24'd65536;
					p = 24'd65536;
				end
				2: begin
					l = 13'd0;
					r = 24'd0;
					p = 24'h800000;
				end
				3: begin
					l = 13'd4096;
					r = 24'hFFFFFF;
					p = 24'h7FFFFF;
				end
				4: l = 13'h1FFF;
				default: ;
			endcase
			ul = (l == 0) ? 1 : (l > DEPTH) ? DEPTH : int'(l);
			if ($urandom_range(0, 1) != 0)
				v = INV_W'((1 << 24) / ul);
			else
				v = INV_W'($urandom_range(4096, 33554431));
			if (seg == 2)
				v = 25'h1FFFFFF;
			else if (seg == 3)
				v = 25'd4096;
			// One segment keeps the length so the store carries over.
			apply_setting(l, r, p, v, seg != 6);
			fill_segment(SEG_ITEMS);
			if (seg == 2 || seg == 7)
				hold_request++;
		end

		wait_until_drained();
		if (mismatches == 0)
			$display("tb_record_play_loop_buffer_top: done, clean");
		else
			$display("tb_record_play_loop_buffer_top: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
design/rplb_pkg.sv
design/rplb_store.sv
design/rplb_ctrl.sv
design/rplb_post.sv
design/rplb_fifo.sv
design/record_play_loop_buffer_top.sv
tb/tb_record_play_loop_buffer_top.sv
